// File: src/grey_contrast_stretch_core_defines.svh
// Assertion macros used by the contrast stretch control module.
`ifndef GREY_CONTRAST_STRETCH_CORE_DEFINES_SVH
`define GREY_CONTRAST_STRETCH_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GCS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gcs assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define GCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gcs assertion failed");

`endif

// File: src/gcs_pkg.sv
package gcs_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 8;
  localparam int NUM_W     = 17;
  localparam int DIV_STEPS = 8;
  localparam int CNT_W     = 4;

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_MAP     = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_NORMALISE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CAP   = 1'd1;

  localparam logic [PIX_W-1:0] CAP_RESET  = 8'd64;
  localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;
  localparam logic [PIX_W-1:0] MIN_RESET  = 8'd255;
  localparam logic [PIX_W-1:0] MAX_RESET  = 8'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic measure;
    logic load;
    logic step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

// File: src/gcs_ctrl.sv
`include "grey_contrast_stretch_core_defines.svh"

module gcs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          opcode,
  input  gcs_pkg::stat_t st,
  output logic          in_ready,
  output gcs_pkg::cmd_t cmd
);
  import gcs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (opcode == OP_MEASURE) begin
            cmd.measure = 1'b1;
          end else begin
            cmd.load   = 1'b1;
            state_next = ST_DIVIDE;
          end
        end
      end
      ST_DIVIDE: begin
        if (!st.div_done) begin
          cmd.step = 1'b1;
        end else if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `GCS_ASSERT_IMP(a_out_load_free, cmd.out_load, st.out_free)
  `GCS_ASSERT_IMP(a_no_step_when_done, cmd.step, !st.div_done)
  `GCS_ASSERT_NEXT(a_hold_on_stall,
                   state == ST_DIVIDE && st.div_done && !st.out_free,
                   state == ST_HOLD)

endmodule

// File: src/gcs_datapath.sv
module gcs_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  gcs_pkg::cmd_t                      cmd,
  input  logic                               cfg_wr,
  input  logic [gcs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gcs_pkg::CFG_DAT_W-1:0]      cfg_data,
  input  logic                               frame_start,
  input  logic [gcs_pkg::PIX_W-1:0]          pixel_in,
  input  logic                               out_ready,
  output gcs_pkg::stat_t                     st,
  output logic                               out_valid,
  output logic [gcs_pkg::PIX_W-1:0]          pixel_out
);
  import gcs_pkg::*;

  logic             normalise_enable;
  logic [PIX_W-1:0] max_cap_level;
  logic [PIX_W-1:0] min_seen;
  logic [PIX_W-1:0] max_seen;

  logic [PIX_W-1:0] capped;
  logic [PIX_W-1:0] delta;
  logic [PIX_W:0]   diff;
  logic [NUM_W-1:0] num;
  logic             bypass;
  logic [PIX_W-1:0] bypass_val;
  logic [PIX_W-1:0] base_min;
  logic [PIX_W-1:0] base_max;

  logic [NUM_W-1:0]   num_r;
  logic [PIX_W-1:0]   delta_r;
  logic [2*PIX_W-1:0] dvs;
  logic [PIX_W-1:0]   quo;
  logic [CNT_W-1:0]   cnt;
  logic               chk;
  logic               done;
  logic [2*PIX_W:0]   trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      normalise_enable <= 1'b0;
      max_cap_level    <= CAP_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_NORMALISE: normalise_enable <= cfg_data[0];
        CFG_MAX_CAP:   max_cap_level    <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // A frame start restarts the statistics before this pixel is counted.
  always_comb begin
    base_min = frame_start ? MIN_RESET : min_seen;
    base_max = frame_start ? MAX_RESET : max_seen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_seen <= MIN_RESET;
      max_seen <= MAX_RESET;
    end else if (cmd.measure) begin
      min_seen <= (pixel_in < base_min) ? pixel_in : base_min;
      max_seen <= (pixel_in > base_max) ? pixel_in : base_max;
    end
  end

  // Numerator is (p - min) * 255 + delta / 2, built as a shift and subtract.
  always_comb begin
    capped = (max_seen < max_cap_level) ? max_seen : max_cap_level;
    delta  = capped - min_seen;
    diff   = {1'b0, pixel_in} - {1'b0, min_seen};
    num    = {diff, 8'b0} - {{(NUM_W-PIX_W-1){diff[PIX_W]}}, diff}
             + {{(NUM_W-PIX_W+1){1'b0}}, delta[PIX_W-1:1]};
    bypass = !normalise_enable || (delta == '0);
    if (!normalise_enable) begin
      bypass_val = pixel_in;
    end else begin
      bypass_val = (pixel_in <= min_seen) ? '0 : FULL_SCALE;
    end
  end

  assign trial = {1'b0, num_r[2*PIX_W-1:0]} - {1'b0, dvs};

  // Restoring division: one range check, then one quotient bit per step.
  always_ff @(posedge clk) begin
    if (rst) begin
      chk  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (cmd.load) begin
      chk  <= !bypass;
      done <= bypass;
      cnt  <= CNT_W'(DIV_STEPS);
    end else if (cmd.step) begin
      if (chk) begin
        chk <= 1'b0;
        if (num_r[NUM_W-1] || (num_r[2*PIX_W-1:0] >= {delta_r, 8'b0})) begin
          done <= 1'b1;
        end
      end else begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num_r   <= num;
      delta_r <= delta;
      quo     <= bypass_val;
    end else if (cmd.step) begin
      if (chk) begin
        dvs <= {1'b0, delta_r, 7'b0};
        if (num_r[NUM_W-1]) begin
          quo <= '0;
        end else if (num_r[2*PIX_W-1:0] >= {delta_r, 8'b0}) begin
          quo <= FULL_SCALE;
        end else begin
          quo <= '0;
        end
      end else begin
        dvs <= dvs >> 1;
        quo <= {quo[PIX_W-2:0], !trial[2*PIX_W]};
        if (!trial[2*PIX_W]) begin
          num_r <= {1'b0, trial[2*PIX_W-1:0]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pixel_out <= quo;
    end
  end

  assign st.div_done = done;
  assign st.out_free = !out_valid || out_ready;

endmodule

// File: src/grey_contrast_stretch_core.sv
// Min-max contrast stretch of 8-bit grey pixels. Opcode 0 items measure a
// pixel into the running frame minimum and maximum (frame_start restarts
// them) and give no result. Opcode 1 items return one mapped pixel: the
// divider is bypassed when normalise_enable is clear or the range is empty,
// the result clamps when it falls out of range, and otherwise it comes from
// the eight-step restoring divider that forms the quotient one bit per
// cycle. A finished result waits in the output register while measure items
// keep flowing in. Configuration takes effect on the next item.
module grey_contrast_stretch_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          opcode,
  input  logic                          frame_start,
  input  logic [gcs_pkg::PIX_W-1:0]     pixel_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gcs_pkg::PIX_W-1:0]     pixel_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gcs_pkg::CFG_DAT_W-1:0] cfg_data
);
  import gcs_pkg::*;

  cmd_t  cmd;
  stat_t st;
  logic  cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  gcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .st       (st),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  gcs_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_wr      (cfg_wr),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .frame_start (frame_start),
    .pixel_in    (pixel_in),
    .out_ready   (out_ready),
    .st          (st),
    .out_valid   (out_valid),
    .pixel_out   (pixel_out)
  );

endmodule
